/* hdl/thpc_pkg.sv */
`default_nettype none

package thpc_pkg;

  localparam int unsigned FrontStages = 12;
  localparam int unsigned DivSteps    = 64;
  localparam int unsigned PostStages  = 6;
  localparam int unsigned NumStages   = FrontStages + DivSteps + PostStages;
  localparam int unsigned DivNumW     = 64;
  localparam int unsigned DivDenW     = 31;

  localparam logic [2:0] CfgTempCal  = 3'd0;
  localparam logic [2:0] CfgPressCalA = 3'd1;
  localparam logic [2:0] CfgPressCalB = 3'd2;
  localparam logic [2:0] CfgPressCalC = 3'd3;
  localparam logic [2:0] CfgHumCal   = 3'd4;

  typedef struct packed {
    logic [63:0] ll;
    logic [31:0] cr;
  } mp_t;

  typedef struct packed {
    logic        neg;
    logic        pok;
    logic [31:0] fine;
    logic [16:0] hum;
  } dside_t;

  typedef struct packed {
    logic [31:0] tc;
    logic [31:0] fine;
    logic [31:0] pr;
    logic        pok;
    logic [16:0] hum;
  } res_t;

  function automatic mp_t mul_part(input logic [63:0] a, input logic [63:0] b);
    mp_t         r;
    logic [31:0] c1;
    logic [31:0] c2;
    r.ll = a[31:0] * b[31:0];
    c1   = a[63:32] * b[31:0];
    c2   = a[31:0] * b[63:32];
    r.cr = c1 + c2;
    return r;
  endfunction

  function automatic logic [63:0] mul_join(input mp_t m);
    return m.ll + {m.cr, 32'b0};
  endfunction

  function automatic logic [31:0] asr32(input logic [31:0] x, input int unsigned n);
    return $signed(x) >>> n;
  endfunction

  function automatic logic [63:0] asr64(input logic [63:0] x, input int unsigned n);
    return $signed(x) >>> n;
  endfunction

  function automatic logic [63:0] sx16(input logic [15:0] x);
    return {{48{x[15]}}, x};
  endfunction

endpackage

`default_nettype wire

/* hdl/thpc_div.sv */
`default_nettype none

module thpc_div import thpc_pkg::*; (
  input  logic               clk_i,
  input  logic               adv_i,
  input  logic [DivNumW-1:0] num_i,
  input  logic [DivDenW-1:0] den_i,
  input  dside_t             side_i,
  output logic [DivNumW-1:0] quot_o,
  output dside_t             side_o
);

  logic [DivDenW-1:0] rem_q  [DivSteps];
  logic [DivNumW-1:0] quo_q  [DivSteps];
  logic [DivDenW-1:0] den_q  [DivSteps];
  dside_t             side_q [DivSteps];

  for (genvar i = 0; i < DivSteps; i++) begin : g_step
    logic [DivDenW-1:0] rem_in;
    logic [DivNumW-1:0] quo_in;
    logic [DivDenW-1:0] den_in;
    dside_t             side_in;
    logic [DivDenW:0]   trial;
    logic               ge;

    if (i == 0) begin : g_first
      assign rem_in  = '0;
      assign quo_in  = num_i;
      assign den_in  = den_i;
      assign side_in = side_i;
    end else begin : g_next
      assign rem_in  = rem_q[i-1];
      assign quo_in  = quo_q[i-1];
      assign den_in  = den_q[i-1];
      assign side_in = side_q[i-1];
    end

    assign trial = {rem_in, quo_in[DivNumW-1]};
    assign ge    = trial >= {1'b0, den_in};

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rem_q[i]  <= ge ? DivDenW'(trial - {1'b0, den_in}) : trial[DivDenW-1:0];
        quo_q[i]  <= {quo_in[DivNumW-2:0], ge};
        den_q[i]  <= den_in;
        side_q[i] <= side_in;
      end
    end
  end

  assign quot_o = quo_q[DivSteps-1];
  assign side_o = side_q[DivSteps-1];

endmodule

`default_nettype wire

/* hdl/thp_sensor_compensation_core.sv */
// Temperature, pressure and humidity compensation core.
// Input channel: in_valid_i / in_stall_o with raw_pressure_i, raw_temperature_i and
// raw_humidity_i; an item is taken on a clock edge with valid high and stall low.
// Output channel: out_valid_o / out_stall_i with temperature_centi_o, fine_temperature_o,
// pressure_q24_8_o, pressure_valid_o and humidity_q22_10_o, one result per item.
// Calibration words are written through cfg_we_i / cfg_idx_i / cfg_data_i: index 0
// temperature, 1..3 pressure, 4 humidity; other indexes are ignored. The user
// writes them only while the core is idle; the core itself does not enforce this.
// Throughput: one item per cycle while no stall freezes the pipeline. An item passes
// through 12 front stages, the 64-stage restoring divider of the pressure path, 6 back
// stages and the output register; the first front stage loads on the accepting edge.
// Reset clears all valid bits and calibration words to zero.
// When the receiver stalls, the result holds in the output register and one more item
// lands in a skid register; the pipeline then freezes and in_stall_o rises until the
// skid drains. No item is lost or repeated.
`default_nettype none

module thp_sensor_compensation_core import thpc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [19:0]        raw_pressure_i,
  input  logic [19:0]        raw_temperature_i,
  input  logic [15:0]        raw_humidity_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] temperature_centi_o,
  output logic signed [31:0] fine_temperature_o,
  output logic [31:0]        pressure_q24_8_o,
  output logic               pressure_valid_o,
  output logic [16:0]        humidity_q22_10_o,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [63:0]        cfg_data_i
);

  logic [47:0] temp_cal_q;
  logic [63:0] press_cal_a_q;
  logic [63:0] press_cal_b_q;
  logic [15:0] press_cal_c_q;
  logic [63:0] hum_cal_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_cal_q    <= '0;
      press_cal_a_q <= '0;
      press_cal_b_q <= '0;
      press_cal_c_q <= '0;
      hum_cal_q     <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgTempCal:   temp_cal_q    <= cfg_data_i[47:0];
        CfgPressCalA: press_cal_a_q <= cfg_data_i;
        CfgPressCalB: press_cal_b_q <= cfg_data_i;
        CfgPressCalC: press_cal_c_q <= cfg_data_i[15:0];
        CfgHumCal:    hum_cal_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [15:0]        t1;
  logic [15:0]        t2;
  logic [15:0]        t3;
  logic [15:0]        p1;
  logic signed [15:0] p2;
  logic [15:0]        p3;
  logic [15:0]        p4;
  logic signed [15:0] p5;
  logic [15:0]        p6;
  logic [15:0]        p7;
  logic [15:0]        p8;
  logic [15:0]        p9;
  logic [7:0]         h1;
  logic [15:0]        h2;
  logic [7:0]         h3;
  logic [11:0]        h4;
  logic [11:0]        h5;
  logic [7:0]         h6;

  assign t1 = temp_cal_q[15:0];
  assign t2 = temp_cal_q[31:16];
  assign t3 = temp_cal_q[47:32];
  assign p1 = press_cal_a_q[15:0];
  assign p2 = press_cal_a_q[31:16];
  assign p3 = press_cal_a_q[47:32];
  assign p4 = press_cal_a_q[63:48];
  assign p5 = press_cal_b_q[15:0];
  assign p6 = press_cal_b_q[31:16];
  assign p7 = press_cal_b_q[47:32];
  assign p8 = press_cal_b_q[63:48];
  assign p9 = press_cal_c_q;
  assign h1 = hum_cal_q[7:0];
  assign h2 = hum_cal_q[23:8];
  assign h3 = hum_cal_q[31:24];
  assign h4 = hum_cal_q[43:32];
  assign h5 = hum_cal_q[55:44];
  assign h6 = hum_cal_q[63:56];

  logic                 adv;
  logic [NumStages-1:0] vld_q;
  logic                 out_v_q, skid_v_q;

  assign adv = !skid_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NumStages-2:0], in_valid_i};
    end
  end

  logic [31:0]        s1_ma_q, s1_mb_q;
  logic [19:0]        s1_adp_q, s2_adp_q, s3_adp_q, s4_adp_q, s5_adp_q;
  logic [19:0]        s6_adp_q, s7_adp_q, s8_adp_q;
  logic [15:0]        s1_adh_q, s2_adh_q, s3_adh_q, s4_adh_q, s5_adh_q;
  logic [31:0]        s2_va_q, s2_mc_q;
  logic [31:0]        s3_fine_q, s4_fine_q, s5_fine_q, s6_fine_q, s7_fine_q;
  logic [31:0]        s8_fine_q, s9_fine_q, s10_fine_q, s11_fine_q;
  logic signed [32:0] s4_x1_q;
  logic [31:0]        s4_hv_q;
  logic [63:0]        s5_sq_q;
  logic signed [48:0] s5_x1p5_q, s5_x1p2_q, s6_x1p5_q, s6_x1p2_q, s7_x1p5_q, s7_x1p2_q;
  logic [31:0]        s5_mh5_q, s5_mh6_q, s5_mh3_q;
  mp_t                s6_a_q, s6_b_q;
  logic [31:0]        s6_hx_q, s6_hy_q, s6_hz_q, s7_hx_q, s8_hx_q;
  logic [63:0]        s7_t6_q, s7_t3_q;
  logic [31:0]        s7_myz_q, s8_mw2_q;
  logic [63:0]        s8_x2_q, s8_x1b_q;
  mp_t                s9_a_q;
  logic [63:0]        s9_np_q;
  logic [31:0]        s9_v2_q, s10_v2_q, s11_v2_q;
  logic [63:0]        s10_x1p1_q;
  mp_t                s10_b_q;
  logic [31:0]        s10_qq_q, s11_mh1_q;
  logic signed [30:0] s11_dvs_q;
  logic [63:0]        s11_num_q;
  logic [63:0]        s12_an_q;
  logic [30:0]        s12_ad_q;
  dside_t             s12_side_q;

  logic signed [65:0] sq_w;
  logic signed [48:0] x1p5_w, x1p2_w;
  logic [31:0]        hx_w, hw_w, hq_w, v3_w;
  logic [16:0]        hum_w;

  always_comb begin
    sq_w   = s4_x1_q * s4_x1_q;
    x1p5_w = s4_x1_q * p5;
    x1p2_w = s4_x1_q * p2;
    hx_w   = asr32({2'b0, s5_adh_q, 14'b0} - {h4, 20'b0} - s5_mh5_q + 32'd16384, 15);
    hw_w   = asr32(s8_mw2_q + 32'd8192, 14);
    hq_w   = asr32(s9_v2_q, 15);
    v3_w   = s11_v2_q - asr32(s11_mh1_q, 4);
    if (v3_w[31]) begin
      hum_w = '0;
    end else if (v3_w > 32'd419430400) begin
      hum_w = 17'd102400;
    end else begin
      hum_w = v3_w[28:12];
    end
  end

  logic [DivNumW-1:0] dv_quot;
  dside_t             dv_side;

  thpc_div u_div (
    .clk_i  (clk_i),
    .adv_i  (adv),
    .num_i  (s12_an_q),
    .den_i  (s12_ad_q),
    .side_i (s12_side_q),
    .quot_o (dv_quot),
    .side_o (dv_side)
  );

  logic [63:0] s77_p_q, s78_p_q, s79_p_q, s80_p_q, s81_p_q;
  dside_t      s77_side_q, s78_side_q, s79_side_q, s80_side_q, s81_side_q, s82_side_q;
  mp_t         s78_a_q, s78_b_q, s80_c_q;
  logic [63:0] s79_pss_q, s79_yb_q, s80_yb_q, s81_yb_q, s81_ya_q, s82_sum_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_ma_q  <= ({15'b0, raw_temperature_i[19:3]} - {15'b0, t1, 1'b0}) * {{16{t2[15]}}, t2};
      s1_mb_q  <= ({16'b0, raw_temperature_i[19:4]} - {16'b0, t1})
                * ({16'b0, raw_temperature_i[19:4]} - {16'b0, t1});
      s1_adp_q <= raw_pressure_i;
      s1_adh_q <= raw_humidity_i;

      s2_va_q  <= asr32(s1_ma_q, 11);
      s2_mc_q  <= asr32(s1_mb_q, 12) * {{16{t3[15]}}, t3};
      s2_adp_q <= s1_adp_q;
      s2_adh_q <= s1_adh_q;

      s3_fine_q <= s2_va_q + asr32(s2_mc_q, 14);
      s3_adp_q  <= s2_adp_q;
      s3_adh_q  <= s2_adh_q;

      s4_x1_q   <= $signed({s3_fine_q[31], s3_fine_q}) - 33'sd128000;
      s4_hv_q   <= s3_fine_q - 32'd76800;
      s4_fine_q <= s3_fine_q;
      s4_adp_q  <= s3_adp_q;
      s4_adh_q  <= s3_adh_q;

      s5_sq_q   <= sq_w[63:0];
      s5_x1p5_q <= x1p5_w;
      s5_x1p2_q <= x1p2_w;
      s5_mh5_q  <= s4_hv_q * {{20{h5[11]}}, h5};
      s5_mh6_q  <= s4_hv_q * {{24{h6[7]}}, h6};
      s5_mh3_q  <= s4_hv_q * {24'b0, h3};
      s5_fine_q <= s4_fine_q;
      s5_adp_q  <= s4_adp_q;
      s5_adh_q  <= s4_adh_q;

      s6_a_q    <= mul_part(s5_sq_q, sx16(p6));
      s6_b_q    <= mul_part(s5_sq_q, sx16(p3));
      s6_x1p5_q <= s5_x1p5_q;
      s6_x1p2_q <= s5_x1p2_q;
      s6_hx_q   <= hx_w;
      s6_hy_q   <= asr32(s5_mh6_q, 10);
      s6_hz_q   <= asr32(s5_mh3_q, 11) + 32'd32768;
      s6_fine_q <= s5_fine_q;
      s6_adp_q  <= s5_adp_q;

      s7_t6_q   <= mul_join(s6_a_q);
      s7_t3_q   <= mul_join(s6_b_q);
      s7_x1p5_q <= s6_x1p5_q;
      s7_x1p2_q <= s6_x1p2_q;
      s7_myz_q  <= s6_hy_q * s6_hz_q;
      s7_hx_q   <= s6_hx_q;
      s7_fine_q <= s6_fine_q;
      s7_adp_q  <= s6_adp_q;

      s8_x2_q   <= s7_t6_q + ({{15{s7_x1p5_q[48]}}, s7_x1p5_q} << 17) + (sx16(p4) << 35);
      s8_x1b_q  <= asr64(s7_t3_q, 8) + ({{15{s7_x1p2_q[48]}}, s7_x1p2_q} << 12);
      s8_mw2_q  <= (asr32(s7_myz_q, 10) + 32'd2097152) * {{16{h2[15]}}, h2};
      s8_hx_q   <= s7_hx_q;
      s8_fine_q <= s7_fine_q;
      s8_adp_q  <= s7_adp_q;

      s9_a_q    <= mul_part(64'h0000_8000_0000_0000 + s8_x1b_q, {48'b0, p1});
      s9_np_q   <= ({43'b0, 21'd1048576 - {1'b0, s8_adp_q}} << 31) - s8_x2_q;
      s9_v2_q   <= s8_hx_q * hw_w;
      s9_fine_q <= s8_fine_q;

      s10_x1p1_q <= mul_join(s9_a_q);
      s10_b_q    <= mul_part(s9_np_q, 64'd3125);
      s10_qq_q   <= hq_w * hq_w;
      s10_v2_q   <= s9_v2_q;
      s10_fine_q <= s9_fine_q;

      s11_dvs_q  <= s10_x1p1_q[63:33];
      s11_num_q  <= mul_join(s10_b_q);
      s11_mh1_q  <= asr32(s10_qq_q, 7) * {24'b0, h1};
      s11_v2_q   <= s10_v2_q;
      s11_fine_q <= s10_fine_q;

      s12_an_q        <= s11_num_q[63] ? 64'd0 - s11_num_q : s11_num_q;
      s12_ad_q        <= s11_dvs_q[30] ? 31'd0 - s11_dvs_q : s11_dvs_q;
      s12_side_q.neg  <= s11_num_q[63] ^ s11_dvs_q[30];
      s12_side_q.pok  <= s11_dvs_q != '0;
      s12_side_q.fine <= s11_fine_q;
      s12_side_q.hum  <= hum_w;

      s77_p_q    <= dv_side.neg ? 64'd0 - dv_quot : dv_quot;
      s77_side_q <= dv_side;

      s78_a_q    <= mul_part(asr64(s77_p_q, 13), asr64(s77_p_q, 13));
      s78_b_q    <= mul_part(s77_p_q, sx16(p8));
      s78_p_q    <= s77_p_q;
      s78_side_q <= s77_side_q;

      s79_pss_q  <= mul_join(s78_a_q);
      s79_yb_q   <= asr64(mul_join(s78_b_q), 19);
      s79_p_q    <= s78_p_q;
      s79_side_q <= s78_side_q;

      s80_c_q    <= mul_part(s79_pss_q, sx16(p9));
      s80_yb_q   <= s79_yb_q;
      s80_p_q    <= s79_p_q;
      s80_side_q <= s79_side_q;

      s81_ya_q   <= asr64(mul_join(s80_c_q), 25);
      s81_yb_q   <= s80_yb_q;
      s81_p_q    <= s80_p_q;
      s81_side_q <= s80_side_q;

      s82_sum_q  <= s81_p_q + s81_ya_q + s81_yb_q;
      s82_side_q <= s81_side_q;
    end
  end

  res_t        item;
  logic [63:0] pfin;
  logic [31:0] tc5;

  always_comb begin
    pfin      = asr64(s82_sum_q, 8) + (sx16(p7) << 4);
    tc5       = {s82_side_q.fine[29:0], 2'b0} + s82_side_q.fine + 32'd128;
    item.tc   = asr32(tc5, 8);
    item.fine = s82_side_q.fine;
    item.pr   = s82_side_q.pok ? pfin[31:0] : '0;
    item.pok  = s82_side_q.pok;
    item.hum  = s82_side_q.hum;
  end

  res_t out_q, skid_q;
  logic out_fire, take, load_out;

  assign out_fire = out_v_q && !out_stall_i;
  assign take     = adv && vld_q[NumStages-1];
  assign load_out = !out_v_q || out_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (out_fire) begin
        skid_v_q <= 1'b0;
      end
    end else if (load_out) begin
      out_v_q <= take;
    end else if (take) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (out_fire) begin
        out_q <= skid_q;
      end
    end else if (load_out) begin
      out_q <= item;
    end else if (take) begin
      skid_q <= item;
    end
  end

  assign in_stall_o          = !adv;
  assign out_valid_o         = out_v_q;
  assign temperature_centi_o = out_q.tc;
  assign fine_temperature_o  = out_q.fine;
  assign pressure_q24_8_o    = out_q.pr;
  assign pressure_valid_o    = out_q.pok;
  assign humidity_q22_10_o   = out_q.hum;

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid holds an item while the output register is empty");

  a_press_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !out_q.pok) |-> (out_q.pr == '0))
    else $error("invalid pressure result is not zero");

  a_hum_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> (out_q.hum <= 17'd102400))
    else $error("humidity result above clamp limit");

endmodule

`default_nettype wire
